>>> design/clip_voice_fade_duck_mixer_macros.svh
// ----------------------------------------------------------------------------
// Clip voice mixer assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous rst_n.
// ----------------------------------------------------------------------------
`ifndef CLIP_VOICE_FADE_DUCK_MIXER_MACROS_SVH
`define CLIP_VOICE_FADE_DUCK_MIXER_MACROS_SVH

// Same-cycle implication.
`define CVFDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CVFDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cvfdm_pkg.sv
// ----------------------------------------------------------------------------
// Clip voice mixer package
// Word types, register indexes, operation codes and rounding helpers.
// ----------------------------------------------------------------------------
package cvfdm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 32;
  localparam int GAIN_W   = 17;
  localparam int FRAC_SH  = 32;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] FADE_STEP_RESET = GAIN_W'(46);

  // Product widths of the shared multiplier
  localparam int PROD_CV_W = SAMPLE_W + GAIN_W;
  localparam int TERM_W    = PROD_CV_W + GAIN_W;
  localparam int MUL_A_W   = PROD_CV_W;
  localparam int MUL_B_W   = GAIN_W + 1;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = TERM_W + 2;
  localparam int Q_W       = ACC_W - FRAC_SH;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SH - 1);

  typedef enum logic [1:0] {
    OP_MIX  = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2,
    OP_FADE = 2'd3
  } op_t;

  localparam logic [2:0] REG_REGION_START = 3'd0;
  localparam logic [2:0] REG_REGION_END   = 3'd1;
  localparam logic [2:0] REG_LOOP_ENABLE  = 3'd2;
  localparam logic [2:0] REG_CLIP_VOLUME  = 3'd3;
  localparam logic [2:0] REG_DUCK_ENABLE  = 3'd4;
  localparam logic [2:0] REG_DUCK_GAIN    = 3'd5;
  localparam logic [2:0] REG_FADE_STEP    = 3'd6;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [SAMPLE_W-1:0] clip_left;
    logic signed [SAMPLE_W-1:0] clip_right;
    logic                       clip_valid;
    logic signed [SAMPLE_W-1:0] mic_left;
    logic signed [SAMPLE_W-1:0] mic_right;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic signed [SAMPLE_W-1:0] board_left;
    logic signed [SAMPLE_W-1:0] board_right;
    logic                       board_active;
    logic [FRAME_W-1:0]         next_frame;
    logic                       playing;
  } out_word_t;

  // Round half up by 2^FRAC_SH, then saturate to one sample.
  function automatic logic [SAMPLE_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] t;
    logic [Q_W-1:0]   q;
    t = acc + ROUND_HALF;
    q = t[ACC_W-1:FRAC_SH];
    if (q[Q_W-1:SAMPLE_W-1] == '0 || q[Q_W-1:SAMPLE_W-1] == '1) begin
      return q[SAMPLE_W-1:0];
    end
    return q[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage

>>> design/clip_voice_fade_duck_mixer.sv
// ----------------------------------------------------------------------------
// Clip voice mixer
// One stereo clip voice with fade-out and mic ducking, mixed over a mic.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one word per audio frame or control command (mix, play, stop now,
//    stop with fade). A word is taken when in_valid is high and in_stall low.
//  - out_*: exactly one result word per input word, in order, taken when
//    out_valid is high and out_stall low.
//  - cfg_*: register writes (index, data); cfg_ready is always high. Write
//    only while no word is in flight.
// Sequence: a word is taken in the idle state, then six multiply steps on the one
// shared 33x18 signed multiplier (clip times volume, that times fade gain,
// mic times duck gain, per channel) and a final step to round, saturate and
// load the output register. The block takes no new word until the final step
// has loaded the output register and it is back in the idle state.
// Stall: the finished result waits in the output register; a new word is
// still accepted and computed, and holds in the final step until the output
// register is free.
// Reset: voice off, fade off, fade level unity, cursor zero, registers at
// their defaults, no result pending.
// ----------------------------------------------------------------------------
`include "clip_voice_fade_duck_mixer_macros.svh"

module clip_voice_fade_duck_mixer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cvfdm_pkg::in_word_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cvfdm_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import cvfdm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  // Multiplier schedule
  localparam logic [2:0] STEP_CV_L   = 3'd0;
  localparam logic [2:0] STEP_CV_R   = 3'd1;
  localparam logic [2:0] STEP_FADE_L = 3'd2;
  localparam logic [2:0] STEP_FADE_R = 3'd3;
  localparam logic [2:0] STEP_DUCK_L = 3'd4;
  localparam logic [2:0] STEP_DUCK_R = 3'd5;

  // Control state
  state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic voice_on_r, voice_on_nxt;
  logic fade_active_r, fade_active_nxt;
  logic [GAIN_W-1:0] fade_level_r, fade_level_nxt;
  logic [FRAME_W-1:0] play_pos_r, play_pos_nxt;
  logic out_valid_r, out_valid_nxt;

  // Configuration registers
  logic [FRAME_W-1:0] region_start_r, region_end_r;
  logic loop_enable_r, duck_enable_r;
  logic [GAIN_W-1:0] clip_volume_r, duck_gain_r, fade_step_r;

  // Latched operands and result fields of the word at work
  logic signed [SAMPLE_W-1:0] clip_l_r, clip_r_r, mic_l_r, mic_r_r;
  logic [GAIN_W-1:0] fade_op_r, duck_op_r;
  logic res_active_r, res_playing_r;
  logic [FRAME_W-1:0] res_next_r;

  // Products
  logic signed [PROD_CV_W-1:0] pl_r, pr_r, ml_r, mr_r;
  logic signed [TERM_W-1:0] tl_r, tr_r;
  out_word_t out_data_r;

  logic in_fire, out_fire, load_out;
  logic in_region, take, at_end;
  logic [FRAME_W-1:0] pos_adv;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [ACC_W-1:0] tl_ext, tr_ext, ml_sh, mr_sh;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Cursor bookkeeping for a mix word
  assign in_region = play_pos_r < region_end_r;
  assign take      = in_region && in_data.clip_valid;
  assign pos_adv   = take ? play_pos_r + FRAME_W'(1) : play_pos_r;
  assign at_end    = !in_data.clip_valid || (pos_adv >= region_end_r);

  // Voice state update, done once at acceptance
  always_comb begin
    voice_on_nxt    = voice_on_r;
    fade_active_nxt = fade_active_r;
    fade_level_nxt  = fade_level_r;
    play_pos_nxt    = play_pos_r;
    if (in_fire) begin
      unique case (in_data.operation) inside
        OP_PLAY: begin
          play_pos_nxt    = region_start_r;
          voice_on_nxt    = 1'b1;
          fade_active_nxt = 1'b0;
          fade_level_nxt  = UNITY_GAIN;
        end
        OP_STOP, OP_FADE: begin
          if (in_data.operation == OP_FADE && voice_on_r) begin
            fade_active_nxt = 1'b1;
          end else begin
            voice_on_nxt    = 1'b0;
            fade_active_nxt = 1'b0;
            fade_level_nxt  = UNITY_GAIN;
          end
        end
        default: begin
          if (voice_on_r) begin
            play_pos_nxt = pos_adv;
            // Step the fade only on a consumed frame
            if (take && fade_active_r) begin
              if (fade_level_r <= fade_step_r) begin
                voice_on_nxt    = 1'b0;
                fade_active_nxt = 1'b0;
                fade_level_nxt  = UNITY_GAIN;
              end else begin
                fade_level_nxt = fade_level_r - fade_step_r;
              end
            end
            if (at_end) begin
              if (loop_enable_r) begin
                play_pos_nxt = region_start_r;
              end else begin
                voice_on_nxt = 1'b0;
              end
            end
          end
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MUL;
          step_nxt  = STEP_CV_L;
        end
      end
      S_MUL: begin
        if (step_r == STEP_DUCK_R) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_FIN: begin
        // Hold here until the output register is free
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      STEP_CV_L: begin
        mul_a = MUL_A_W'(clip_l_r);
        mul_b = {1'b0, clip_volume_r};
      end
      STEP_CV_R: begin
        mul_a = MUL_A_W'(clip_r_r);
        mul_b = {1'b0, clip_volume_r};
      end
      STEP_FADE_L: begin
        mul_a = pl_r;
        mul_b = {1'b0, fade_op_r};
      end
      STEP_FADE_R: begin
        mul_a = pr_r;
        mul_b = {1'b0, fade_op_r};
      end
      STEP_DUCK_L: begin
        mul_a = MUL_A_W'(mic_l_r);
        mul_b = {1'b0, duck_op_r};
      end
      STEP_DUCK_R: begin
        mul_a = MUL_A_W'(mic_r_r);
        mul_b = {1'b0, duck_op_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Align terms: clip term has 32 fraction bits, mic term 16
  assign tl_ext = ACC_W'(tl_r);
  assign tr_ext = ACC_W'(tr_r);
  assign ml_sh  = ACC_W'(ml_r) << (FRAC_SH / 2);
  assign mr_sh  = ACC_W'(mr_r) << (FRAC_SH / 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      step_r         <= STEP_CV_L;
      voice_on_r     <= 1'b0;
      fade_active_r  <= 1'b0;
      fade_level_r   <= UNITY_GAIN;
      play_pos_r     <= '0;
      out_valid_r    <= 1'b0;
      region_start_r <= '0;
      region_end_r   <= '1;
      loop_enable_r  <= 1'b0;
      clip_volume_r  <= UNITY_GAIN;
      duck_enable_r  <= 1'b0;
      duck_gain_r    <= UNITY_GAIN;
      fade_step_r    <= FADE_STEP_RESET;
    end else begin
      state_r       <= state_nxt;
      step_r        <= step_nxt;
      voice_on_r    <= voice_on_nxt;
      fade_active_r <= fade_active_nxt;
      fade_level_r  <= fade_level_nxt;
      play_pos_r    <= play_pos_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_REGION_START: region_start_r <= cfg_data[FRAME_W-1:0];
          REG_REGION_END:   region_end_r   <= cfg_data[FRAME_W-1:0];
          REG_LOOP_ENABLE:  loop_enable_r  <= cfg_data[0];
          REG_CLIP_VOLUME:  clip_volume_r  <= cfg_data[GAIN_W-1:0];
          REG_DUCK_ENABLE:  duck_enable_r  <= cfg_data[0];
          REG_DUCK_GAIN:    duck_gain_r    <= cfg_data[GAIN_W-1:0];
          REG_FADE_STEP:    fade_step_r    <= cfg_data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload path
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_next_r    <= play_pos_nxt;
      res_playing_r <= voice_on_nxt;
      // Voice off passes the mic through at unity; control words send zero
      if (in_data.operation == OP_MIX) begin
        mic_l_r <= in_data.mic_left;
        mic_r_r <= in_data.mic_right;
      end else begin
        mic_l_r <= '0;
        mic_r_r <= '0;
      end
      if (in_data.operation == OP_MIX && voice_on_r) begin
        res_active_r <= 1'b1;
        fade_op_r    <= fade_active_r ? fade_level_r : UNITY_GAIN;
        duck_op_r    <= duck_enable_r ? duck_gain_r : UNITY_GAIN;
      end else begin
        res_active_r <= 1'b0;
        fade_op_r    <= UNITY_GAIN;
        duck_op_r    <= UNITY_GAIN;
      end
      if (in_data.operation == OP_MIX && voice_on_r && take) begin
        clip_l_r <= in_data.clip_left;
        clip_r_r <= in_data.clip_right;
      end else begin
        clip_l_r <= '0;
        clip_r_r <= '0;
      end
    end
    if (state_r == S_MUL) begin
      unique case (step_r)
        STEP_CV_L:   pl_r <= mul_p[PROD_CV_W-1:0];
        STEP_CV_R:   pr_r <= mul_p[PROD_CV_W-1:0];
        STEP_FADE_L: tl_r <= mul_p[TERM_W-1:0];
        STEP_FADE_R: tr_r <= mul_p[TERM_W-1:0];
        STEP_DUCK_L: ml_r <= mul_p[PROD_CV_W-1:0];
        STEP_DUCK_R: mr_r <= mul_p[PROD_CV_W-1:0];
        default: begin
        end
      endcase
    end
    if (load_out) begin
      out_data_r.out_left     <= round_sat(tl_ext + ml_sh);
      out_data_r.out_right    <= round_sat(tr_ext + mr_sh);
      out_data_r.board_left   <= round_sat(tl_ext);
      out_data_r.board_right  <= round_sat(tr_ext);
      out_data_r.board_active <= res_active_r;
      out_data_r.next_frame   <= res_next_r;
      out_data_r.playing      <= res_playing_r;
    end
  end

  // Checks
  `CVFDM_ASSERT_NEXT(a_start_mul, in_fire, state_r == S_MUL && step_r == STEP_CV_L,
                     "word accepted but multiply sequence did not start")
  `CVFDM_ASSERT_NEXT(a_mul_to_fin, state_r == S_MUL && step_r == STEP_DUCK_R,
                     state_r == S_FIN, "multiply sequence did not end in the final step")
  `CVFDM_ASSERT_NEXT(a_hold_fin, state_r == S_FIN && out_valid_r && out_stall,
                     state_r == S_FIN && out_valid_r, "pending result overwritten while stalled")
  `CVFDM_ASSERT_NOW(a_fade_nonzero, 1'b1, fade_level_r != '0, "fade level reached zero")

endmodule
